@@ rtl/bffpa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bffpa_pkg
// Shared types and codes for the bitmap first-fit page allocator.
// ----------------------------------------------------------------------------
package bffpa_pkg;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned SIZE_W = 23;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_TBL_FULL  = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [22:0] size_bytes;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [1:0]  status;
      logic [22:0] used_bytes;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN,
      S_MARK_RD,
      S_MARK,
      S_FIND_RD,
      S_FIND,
      S_SHIFT_RD,
      S_SHIFT,
      S_DONE
   } state_type;

endpackage : bffpa_pkg
`default_nettype wire

@@ rtl/bffpa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bffpa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bffpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 128
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : bffpa_ram
`default_nettype wire

@@ rtl/bitmap_first_fit_page_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_fit_page_allocator_top
// First-fit page allocator with a used-page bitmap and an ordered grant table.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes every byte of the bitmap; busy is high
// during it. An allocate is dominated by the bitmap scan, which reads one byte
// (eight pages) at a time through the map RAM's read port, with a read state
// and a scan state per byte. A free searches the table entry by entry, clears
// the bitmap bits of the found grant and shifts the later table entries down.
// One item is worked at a time; the result is shown on rsp_valid for one cycle
// and the receiver cannot stall it.
// Reset is synchronous and active high; it clears control state and base_ff.
// ----------------------------------------------------------------------------
module bitmap_first_fit_page_allocator_top
   import bffpa_pkg::*;
#(
   parameter int unsigned MAP_BYTES     = 128,
   parameter int unsigned PAGE_BYTES    = 4096,
   parameter int unsigned TABLE_ENTRIES = 128
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  req_type      req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [31:0]  csr_data
);

   // Derived sizes. Page numbers carry one extra bit so they can hold the page count.
   localparam int unsigned PAGES   = MAP_BYTES * 8;
   localparam int unsigned MA_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int unsigned PG_W    = $clog2(PAGES) + 1;
   localparam int unsigned TA_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned TC_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned PSH     = $clog2(PAGE_BYTES);
   localparam int unsigned ENT_W   = 2 * PG_W;
   localparam int unsigned UT_W    = PG_W + PSH + 1;

   state_type state_ff, state_in;

   logic [31:0]      base_ff;
   req_type          req_ff, req_in;
   logic [PG_W-1:0]  pages_ff, pages_in;       // requested page count
   logic [PG_W-1:0]  run_ff, run_in;           // current free run length
   logic [PG_W-1:0]  rstart_ff, rstart_in;     // start of the current run
   logic [PG_W-1:0]  pcur_ff, pcur_in;         // page pointer for scan and mark
   logic [PG_W-1:0]  mend_ff, mend_in;         // one past the last page to mark
   logic             mset_ff, mset_in;         // mark sets (alloc) or clears (free)
   logic [TC_W-1:0]  cnt_ff, cnt_in;
   logic [TC_W-1:0]  tidx_ff, tidx_in;
   logic [UT_W-1:0]  used_ff, used_in;
   logic [1:0]       stat_ff, stat_in;
   logic [31:0]      gaddr_ff, gaddr_in;
   logic             clr_ff, clr_in;           // clearing pass active
   logic [MA_W:0]    clr_idx_ff, clr_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Bitmap RAM.
   logic             map_we;
   logic [MA_W-1:0]  map_wa, map_ra;
   logic [7:0]       map_wd, map_rd;
   // Grant table RAM: {start page, page count}.
   logic             tbl_we;
   logic [TA_W-1:0]  tbl_wa, tbl_ra;
   logic [ENT_W-1:0] tbl_wd, tbl_rd;

   bffpa_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_rd)
   );

   bffpa_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_tbl (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_wa), .wr_data(tbl_wd),
      .rd_addr(tbl_ra), .rd_data(tbl_rd)
   );

   // Page count from byte size: round up to whole pages.
   logic [SIZE_W:0]  size_round;
   logic [PG_W-1:0]  pages_calc;
   logic             too_long;
   assign size_round = {1'b0, req_ff.size_bytes} + (SIZE_W+1)'(PAGE_BYTES - 1);
   always_comb begin
      logic [SIZE_W:0] q;
      q          = size_round >> PSH;
      too_long   = (q > (SIZE_W+1)'(PAGES));
      pages_calc = PG_W'(q);
   end

   // Scan of one map byte: run through eight pages, MSB is the lowest page.
   logic [PG_W-1:0] scan_run, scan_start;
   logic            scan_hit;
   logic [PG_W-1:0] scan_hit_start;
   always_comb begin
      logic [PG_W-1:0] r, s, p;
      r = run_ff;
      s = rstart_ff;
      scan_hit = 1'b0;
      scan_hit_start = '0;
      for (int b = 0; b < 8; b++) begin
         p = pcur_ff + PG_W'(b);
         if (r == '0) s = p;
         if (map_rd[7-b]) r = '0;
         else r = r + 1'b1;
         if (!scan_hit && r == pages_ff) begin
            scan_hit = 1'b1;
            scan_hit_start = s;
         end
      end
      scan_run   = r;
      scan_start = s;
   end

   // Mark mask for the byte that holds page pcur_ff (pointer aligned down to the byte).
   logic [7:0] mark_mask;
   always_comb begin
      logic [PG_W-1:0] p;
      mark_mask = '0;
      for (int b = 0; b < 8; b++) begin
         p = {pcur_ff[PG_W-1:3], 3'b000} + PG_W'(b);
         if (p >= rstart_ff && p < mend_ff) mark_mask[7-b] = 1'b1;
      end
   end

   logic [31:0] ent_addr;
   assign ent_addr = base_ff + (32'(tbl_rd[ENT_W-1:PG_W]) << PSH);

   logic [UT_W-1:0] ent_bytes;
   assign ent_bytes = UT_W'(tbl_rd[PG_W-1:0]) << PSH;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start && !busy) state_in = S_CHECK;
         S_CHECK: begin
            if (req_ff.func == FUNC_FREE) begin
               state_in = (cnt_ff == '0) ? S_DONE : S_FIND_RD;
            end else if (req_ff.size_bytes == '0) begin
               state_in = S_DONE;
            end else if (cnt_ff >= TC_W'(TABLE_ENTRIES)) begin
               state_in = S_DONE;
            end else if (too_long) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD:  state_in = S_SCAN;
         S_SCAN: begin
            if (scan_hit) state_in = S_MARK_RD;
            else if (pcur_ff + PG_W'(8) >= PG_W'(PAGES)) state_in = S_DONE;
            else state_in = S_SCAN_RD;
         end
         S_MARK_RD:  state_in = S_MARK;
         S_MARK: begin
            if ({pcur_ff[PG_W-1:3], 3'b000} + PG_W'(8) >= mend_ff) begin
               state_in = mset_ff ? S_DONE : S_SHIFT_RD;
            end else begin
               state_in = S_MARK_RD;
            end
         end
         S_FIND_RD:  state_in = S_FIND;
         S_FIND: begin
            if (ent_addr == req_ff.free_address) state_in = S_MARK_RD;
            else if (tidx_ff + 1'b1 >= cnt_ff) state_in = S_DONE;
            else state_in = S_FIND_RD;
         end
         S_SHIFT_RD: state_in = (tidx_ff + 1'b1 >= cnt_ff) ? S_DONE : S_SHIFT;
         S_SHIFT:    state_in = S_SHIFT_RD;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      req_in       = req_ff;
      pages_in     = pages_ff;
      run_in       = run_ff;
      rstart_in    = rstart_ff;
      pcur_in      = pcur_ff;
      mend_in      = mend_ff;
      mset_in      = mset_ff;
      cnt_in       = cnt_ff;
      tidx_in      = tidx_ff;
      used_in      = used_ff;
      stat_in      = stat_ff;
      gaddr_in     = gaddr_ff;
      clr_in       = clr_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = 1'b0;
      map_we = 1'b0;
      map_wa = pcur_ff[MA_W+2:3];
      map_wd = '0;
      map_ra = pcur_ff[MA_W+2:3];
      tbl_we = 1'b0;
      tbl_wa = tidx_ff[TA_W-1:0];
      tbl_wd = tbl_rd;
      tbl_ra = tidx_ff[TA_W-1:0];

      if (clr_ff) begin
         map_we     = 1'b1;
         map_wa     = clr_idx_ff[MA_W-1:0];
         map_wd     = '0;
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == (MA_W+1)'(MAP_BYTES - 1)) clr_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               req_in   = req_data;
               stat_in  = ST_OK;
               gaddr_in = '0;
               run_in   = '0;
               rstart_in = '0;
               pcur_in  = '0;
               tidx_in  = '0;
            end
         end
         S_CHECK: begin
            pages_in = pages_calc;
            if (req_ff.func == FUNC_FREE) begin
               if (cnt_ff == '0) stat_in = ST_NOT_FOUND;
            end else if (req_ff.size_bytes == '0) begin
               stat_in = ST_NO_SPACE;
            end else if (cnt_ff >= TC_W'(TABLE_ENTRIES)) begin
               stat_in = ST_TBL_FULL;
            end else if (too_long) begin
               stat_in = ST_NO_SPACE;
            end
         end
         S_SCAN: begin
            run_in    = scan_run;
            rstart_in = scan_start;
            pcur_in   = pcur_ff + PG_W'(8);
            if (scan_hit) begin
               rstart_in = scan_hit_start;
               pcur_in   = scan_hit_start;
               mend_in   = scan_hit_start + pages_ff;
               mset_in   = 1'b1;
            end else if (pcur_ff + PG_W'(8) >= PG_W'(PAGES)) begin
               stat_in = ST_NO_SPACE;
            end
         end
         S_MARK: begin
            map_we = 1'b1;
            map_wd = mset_ff ? (map_rd | mark_mask) : (map_rd & ~mark_mask);
            pcur_in = {pcur_ff[PG_W-1:3], 3'b000} + PG_W'(8);
            if ({pcur_ff[PG_W-1:3], 3'b000} + PG_W'(8) >= mend_ff && mset_ff) begin
               tbl_we   = 1'b1;
               tbl_wa   = cnt_ff[TA_W-1:0];
               tbl_wd   = {rstart_ff, pages_ff};
               cnt_in   = cnt_ff + 1'b1;
               used_in  = used_ff + (UT_W'(pages_ff) << PSH);
               gaddr_in = base_ff + (32'(rstart_ff) << PSH);
            end
         end
         S_FIND: begin
            if (ent_addr == req_ff.free_address) begin
               rstart_in = tbl_rd[ENT_W-1:PG_W];
               pcur_in   = tbl_rd[ENT_W-1:PG_W];
               mend_in   = tbl_rd[ENT_W-1:PG_W] + tbl_rd[PG_W-1:0];
               mset_in   = 1'b0;
               used_in   = (used_ff >= ent_bytes) ? used_ff - ent_bytes : '0;
            end else if (tidx_ff + 1'b1 >= cnt_ff) begin
               stat_in = ST_NOT_FOUND;
            end else begin
               tidx_in = tidx_ff + 1'b1;
            end
         end
         S_SHIFT_RD: begin
            // Read the entry above; it is written one place down next cycle.
            tbl_ra = TA_W'(tidx_ff + 1'b1);
            if (tidx_ff + 1'b1 >= cnt_ff) cnt_in = cnt_ff - 1'b1;
         end
         S_SHIFT: begin
            tbl_we  = 1'b1;
            tbl_wa  = tidx_ff[TA_W-1:0];
            tbl_wd  = tbl_rd;
            tidx_in = tidx_ff + 1'b1;
         end
         S_DONE:  rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         cnt_ff       <= '0;
         used_ff      <= '0;
         clr_ff       <= 1'b1;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         clr_ff       <= clr_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) base_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      pages_ff  <= pages_in;
      run_ff    <= run_in;
      rstart_ff <= rstart_in;
      pcur_ff   <= pcur_in;
      mend_ff   <= mend_in;
      mset_ff   <= mset_in;
      tidx_ff   <= tidx_in;
      stat_ff   <= stat_in;
      gaddr_ff  <= gaddr_in;
   end

   // Outputs.
   always_comb begin
      busy      = (state_ff != S_IDLE) || clr_ff;
      csr_ready = 1'b1;
      rsp_valid = rsp_valid_ff;
      rsp_data.granted_address = gaddr_ff;
      rsp_data.status          = stat_ff;
      rsp_data.used_bytes      = used_ff[SIZE_W-1:0];
   end

endmodule : bitmap_first_fit_page_allocator_top
`default_nettype wire
